FILE: src/yc2rgb_pkg.sv
// Shared types, widths and constants for the 4:2:2 YCbCr pair to RGB converter.
// Depends on nothing; every other file of the block takes names from here.
`default_nettype none

package yc2rgb_pkg;

	// Fixed widths of samples, coefficients and the APB port
	localparam int SAMPLE_W = 8;
	localparam int COEF_W   = 16;
	localparam int APB_W    = 32;
	localparam int ADDR_W   = 5;
	localparam int IDX_W    = 3;

	// Offset samples are signed and one bit wider than a sample
	localparam int OFS_W  = SAMPLE_W + 1;
	localparam int PROD_W = OFS_W + COEF_W;
	localparam int SUM_W  = PROD_W + 2;

	localparam int COEF_FRAC_BITS_DEF = 13;

	localparam logic signed [OFS_W-1:0] LUMA_OFFSET   = 9'sd16;
	localparam logic signed [OFS_W-1:0] CHROMA_OFFSET = 9'sd128;
	localparam logic [SAMPLE_W-1:0]     PIX_MAX       = 8'hff;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_LUMA_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_CB_TO_GREEN = 3'd1;
	localparam logic [IDX_W-1:0] REG_CR_TO_GREEN = 3'd2;
	localparam logic [IDX_W-1:0] REG_CB_TO_BLUE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CR_TO_RED   = 3'd4;

	// BT.601 reset coefficients, Q13
	localparam logic signed [COEF_W-1:0] RST_LUMA_GAIN   = 16'sd9539;
	localparam logic signed [COEF_W-1:0] RST_CB_TO_GREEN = -16'sd3209;
	localparam logic signed [COEF_W-1:0] RST_CR_TO_GREEN = -16'sd6660;
	localparam logic signed [COEF_W-1:0] RST_CB_TO_BLUE  = 16'sd16525;
	localparam logic signed [COEF_W-1:0] RST_CR_TO_RED   = 16'sd13074;

	typedef logic signed [COEF_W-1:0] coef_val_t;

	// Coefficient set handed from the register file to the datapath
	typedef struct packed {
		coef_val_t luma_gain;
		coef_val_t cb_to_green;
		coef_val_t cr_to_green;
		coef_val_t cb_to_blue;
		coef_val_t cr_to_red;
	} coef_t;

endpackage

`default_nettype wire

FILE: src/yc2rgb_if.sv
// Stream interfaces: 4:2:2 pixel pair in, two RGB pixels out, valid/ready.
// Depends on yc2rgb_pkg for sample widths.
`default_nettype none

interface yc2rgb_pair_if;
	logic                               valid;
	logic                               ready;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    luma_first;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    luma_second;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    chroma_blue;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    chroma_red;

	modport source(output valid, luma_first, luma_second, chroma_blue, chroma_red,
		input ready);
	modport sink(input valid, luma_first, luma_second, chroma_blue, chroma_red,
		output ready);
endinterface

interface yc2rgb_rgb_if;
	logic                               valid;
	logic                               ready;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    red_first;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    green_first;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    blue_first;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    red_second;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    green_second;
	logic [yc2rgb_pkg::SAMPLE_W-1:0]    blue_second;

	modport source(output valid, red_first, green_first, blue_first,
		red_second, green_second, blue_second, input ready);
	modport sink(input valid, red_first, green_first, blue_first,
		red_second, green_second, blue_second, output ready);
endinterface

`default_nettype wire

FILE: src/yc2rgb_cfg.sv
// APB register file holding the five signed colour matrix coefficients.
// Depends on yc2rgb_pkg for register indexes, reset values and coef_t.
`default_nettype none

module yc2rgb_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [yc2rgb_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [yc2rgb_pkg::APB_W-1:0]   pwdata,
	output logic      [yc2rgb_pkg::APB_W-1:0]   prdata,
	output logic                                pready,
	output yc2rgb_pkg::coef_t                   coef
);

	yc2rgb_pkg::coef_t                 coef_q;
	logic [yc2rgb_pkg::IDX_W-1:0]      idx;
	logic                              wr_en;
	yc2rgb_pkg::coef_val_t             wr_val;
	yc2rgb_pkg::coef_val_t             rd_val;

	assign idx    = paddr[yc2rgb_pkg::ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite & pready;
	assign wr_val = pwdata[yc2rgb_pkg::COEF_W-1:0];
	assign pready = 1'b1;
	assign coef   = coef_q;

	// Write the addressed coefficient; drop writes beyond the last register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.luma_gain   <= yc2rgb_pkg::RST_LUMA_GAIN;
			coef_q.cb_to_green <= yc2rgb_pkg::RST_CB_TO_GREEN;
			coef_q.cr_to_green <= yc2rgb_pkg::RST_CR_TO_GREEN;
			coef_q.cb_to_blue  <= yc2rgb_pkg::RST_CB_TO_BLUE;
			coef_q.cr_to_red   <= yc2rgb_pkg::RST_CR_TO_RED;
		end else if (wr_en) begin
			unique case (idx)
				yc2rgb_pkg::REG_LUMA_GAIN:   coef_q.luma_gain   <= wr_val;
				yc2rgb_pkg::REG_CB_TO_GREEN: coef_q.cb_to_green <= wr_val;
				yc2rgb_pkg::REG_CR_TO_GREEN: coef_q.cr_to_green <= wr_val;
				yc2rgb_pkg::REG_CB_TO_BLUE:  coef_q.cb_to_blue  <= wr_val;
				yc2rgb_pkg::REG_CR_TO_RED:   coef_q.cr_to_red   <= wr_val;
				default: ;
			endcase
		end
	end

	// Read back the addressed coefficient, sign extended
	always_comb begin
		unique case (idx)
			yc2rgb_pkg::REG_LUMA_GAIN:   rd_val = coef_q.luma_gain;
			yc2rgb_pkg::REG_CB_TO_GREEN: rd_val = coef_q.cb_to_green;
			yc2rgb_pkg::REG_CR_TO_GREEN: rd_val = coef_q.cr_to_green;
			yc2rgb_pkg::REG_CB_TO_BLUE:  rd_val = coef_q.cb_to_blue;
			yc2rgb_pkg::REG_CR_TO_RED:   rd_val = coef_q.cr_to_red;
			default:                     rd_val = '0;
		endcase
	end

	assign prdata = yc2rgb_pkg::APB_W'(rd_val);

endmodule

`default_nettype wire

FILE: src/yc2rgb_pipe.sv
// Four-stage conversion pipeline: offset, multiply, sum, shift and clamp.
// Depends on yc2rgb_pkg and the stream interfaces in yc2rgb_if.sv.
`default_nettype none

module yc2rgb_pipe #(
	parameter int COEF_FRAC_BITS = yc2rgb_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire yc2rgb_pkg::coef_t coef,
	yc2rgb_pair_if.sink            pair,
	yc2rgb_rgb_if.source           rgb
);

	localparam int OW = yc2rgb_pkg::OFS_W;
	localparam int PW = yc2rgb_pkg::PROD_W;
	localparam int SW = yc2rgb_pkg::SUM_W;
	localparam int BW = yc2rgb_pkg::SAMPLE_W;

	// Per-stage valid and advance
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	// Stage 1: offset samples
	logic signed [OW-1:0] y0_s1, y1_s1, cb_s1, cr_s1;
	// Stage 2: products
	logic signed [PW-1:0] yg0_s2, yg1_s2, cbg_s2, crg_s2, cbb_s2, crr_s2;
	// Stage 3: channel sums
	logic signed [SW-1:0] r0_s3, g0_s3, b0_s3, r1_s3, g1_s3, b1_s3;
	// Stage 4: clamped bytes
	logic [BW-1:0] r0_s4, g0_s4, b0_s4, r1_s4, g1_s4, b1_s4;

	// A stage moves on when it is empty or its successor moves on
	assign adv4 = !v_s4 || rgb.ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign pair.ready = adv1;

	// Floor shift then clamp to 0..255
	function automatic logic [BW-1:0] to_byte(input logic signed [SW-1:0] sum);
		logic signed [SW-1:0] q;
		q = sum >>> COEF_FRAC_BITS;
		if (sum[SW-1])
			to_byte = '0;
		else if (q[SW-1:BW] != '0)
			to_byte = yc2rgb_pkg::PIX_MAX;
		else
			to_byte = q[BW-1:0];
	endfunction

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= pair.valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// Stage 1: remove the luma and chroma offsets
	always_ff @(posedge clk) begin
		if (adv1 && pair.valid) begin
			y0_s1 <= $signed({1'b0, pair.luma_first})  - yc2rgb_pkg::LUMA_OFFSET;
			y1_s1 <= $signed({1'b0, pair.luma_second}) - yc2rgb_pkg::LUMA_OFFSET;
			cb_s1 <= $signed({1'b0, pair.chroma_blue}) - yc2rgb_pkg::CHROMA_OFFSET;
			cr_s1 <= $signed({1'b0, pair.chroma_red})  - yc2rgb_pkg::CHROMA_OFFSET;
		end
	end

	// Stage 2: one multiplier per term
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			yg0_s2 <= y0_s1 * coef.luma_gain;
			yg1_s2 <= y1_s1 * coef.luma_gain;
			cbg_s2 <= cb_s1 * coef.cb_to_green;
			crg_s2 <= cr_s1 * coef.cr_to_green;
			cbb_s2 <= cb_s1 * coef.cb_to_blue;
			crr_s2 <= cr_s1 * coef.cr_to_red;
		end
	end

	// Stage 3: add the luma term to the chroma terms of each channel
	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			r0_s3 <= SW'(yg0_s2) + SW'(crr_s2);
			g0_s3 <= SW'(yg0_s2) + SW'(cbg_s2) + SW'(crg_s2);
			b0_s3 <= SW'(yg0_s2) + SW'(cbb_s2);
			r1_s3 <= SW'(yg1_s2) + SW'(crr_s2);
			g1_s3 <= SW'(yg1_s2) + SW'(cbg_s2) + SW'(crg_s2);
			b1_s3 <= SW'(yg1_s2) + SW'(cbb_s2);
		end
	end

	// Stage 4: shift and clamp into the output register
	always_ff @(posedge clk) begin
		if (adv4 && v_s3) begin
			r0_s4 <= to_byte(r0_s3);
			g0_s4 <= to_byte(g0_s3);
			b0_s4 <= to_byte(b0_s3);
			r1_s4 <= to_byte(r1_s3);
			g1_s4 <= to_byte(g1_s3);
			b1_s4 <= to_byte(b1_s3);
		end
	end

	assign rgb.valid        = v_s4;
	assign rgb.red_first    = r0_s4;
	assign rgb.green_first  = g0_s4;
	assign rgb.blue_first   = b0_s4;
	assign rgb.red_second   = r1_s4;
	assign rgb.green_second = g1_s4;
	assign rgb.blue_second  = b1_s4;

endmodule

`default_nettype wire

FILE: src/ycbcr422_pair_to_rgb.sv
// Top level: 4:2:2 YCbCr pixel pair to two RGB pixels with a loadable matrix.
// Depends on yc2rgb_pkg, yc2rgb_if.sv, yc2rgb_cfg and yc2rgb_pipe.
//
//   channel   direction  handshake            transaction
//   pair      in         valid/ready          Y0, Y1, Cb, Cr of one pixel pair
//   rgb       out        valid/ready          R, G, B of both pixels
//   apb       in         psel/penable/pready  one coefficient register
//
// One pair enters per clock while pair.ready is high. The offset stage loads
// at the accepting edge, and the result reaches rgb behind the offset,
// multiply, sum and clamp register stages.
// Reset loads the BT.601 coefficients and empties the pipeline.
// Each stage holds while its successor is full and stalled, so bubbles close
// up and nothing is lost or repeated; pair.ready falls only when all four
// stages are full and rgb.ready is low.
`default_nettype none

module ycbcr422_pair_to_rgb #(
	parameter int COEF_FRAC_BITS = yc2rgb_pkg::COEF_FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [yc2rgb_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [yc2rgb_pkg::APB_W-1:0]   pwdata,
	output logic      [yc2rgb_pkg::APB_W-1:0]   prdata,
	output logic                                pready,
	yc2rgb_pair_if.sink                         pair,
	yc2rgb_rgb_if.source                        rgb
);

	yc2rgb_pkg::coef_t coef;

	// Coefficient registers
	yc2rgb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	// Conversion pipeline
	yc2rgb_pipe #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.coef   (coef),
		.pair   (pair),
		.rgb    (rgb)
	);

endmodule

`default_nettype wire
